/* design/lkvc_pkg.sv */
package lkvc_pkg;

  // Default sizing of the store.
  localparam int ENTRIES_DEF  = 16;
  localparam int KEY_BITS_DEF = 32;

  // Field widths fixed by the item format.
  localparam int DATA_BITS = 32;
  localparam int CAP_BITS  = 5;

  // Configuration port.
  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;

  // Register index, taken from the word address (paddr[2]).
  localparam logic REG_CAPACITY = 1'b0;

  // Capacity after reset.
  localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

  // Operation codes.
  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_PUT = 1'b1
  } cmd_t;

  // One input item.
  typedef struct packed {
    cmd_t                        cmd;
    logic signed [DATA_BITS-1:0] lookup_key;
    logic signed [DATA_BITS-1:0] put_value;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic                        found;
    logic signed [DATA_BITS-1:0] read_value;
  } out_item_t;

endpackage

/* design/lkvc_cfg.sv */
module lkvc_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lkvc_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  logic [lkvc_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic [lkvc_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                                pready,
  output logic [lkvc_pkg::CAP_BITS-1:0]       capacity
);
  import lkvc_pkg::*;

  logic [CAP_BITS-1:0] capacity_r;
  logic [CAP_BITS-1:0] capacity_nxt;
  logic                wr_cap;

  // The port never inserts wait states.
  assign pready = 1'b1;

  // A write lands in the access phase; other word addresses are ignored.
  assign wr_cap = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);

  always_comb begin
    capacity_nxt = capacity_r;
    if (wr_cap) begin
      capacity_nxt = pwdata[CAP_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else begin
      capacity_r <= capacity_nxt;
    end
  end

  // Read back the register; unused addresses read as zero.
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_CAPACITY) begin
      prdata = APB_DATA_BITS'(capacity_r);
    end
  end

  assign capacity = capacity_r;

endmodule

/* design/lkvc_store.sv */
module lkvc_store #(
  parameter int ENTRIES  = lkvc_pkg::ENTRIES_DEF,
  parameter int KEY_BITS = lkvc_pkg::KEY_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          op_valid,
  input  lkvc_pkg::in_item_t            op,
  input  logic [lkvc_pkg::CAP_BITS-1:0] capacity,
  output lkvc_pkg::out_item_t           res
);
  import lkvc_pkg::*;

  localparam int AGE_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (CNT_W > CAP_BITS) ? CNT_W : CAP_BITS;

  // Entry storage: keys form a CAM, every entry compared at once.
  logic [KEY_BITS-1:0]  key_r   [ENTRIES];
  logic [DATA_BITS-1:0] value_r [ENTRIES];
  logic [ENTRIES-1:0]   valid_r;
  logic [ENTRIES-1:0]   valid_nxt;
  logic [AGE_W-1:0]     age_r   [ENTRIES];
  logic [AGE_W-1:0]     age_nxt [ENTRIES];
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     count_nxt;

  logic [KEY_BITS-1:0]  key;
  logic [ENTRIES-1:0]   hit_vec;
  logic                 hit;
  logic [DATA_BITS-1:0] hit_value;
  logic [AGE_W-1:0]     hit_age;
  logic [CMP_W-1:0]     eff_cap;
  logic                 full;
  logic [CNT_W-1:0]     count_m1;
  logic [ENTRIES-1:0]   lru_vec;
  logic [ENTRIES-1:0]   free_vec;
  logic [ENTRIES-1:0]   free_first;
  logic [ENTRIES-1:0]   slot_vec;
  logic [ENTRIES-1:0]   wr_vec;
  logic                 is_put;

  // Keys are sign-extended or truncated to the stored key width.
  assign key    = KEY_BITS'(op.lookup_key);
  assign is_put = (op.cmd == CMD_PUT);

  // Parallel compare; valid keys are distinct, so at most one entry hits.
  always_comb begin
    hit_value = '0;
    hit_age   = '0;
    for (int j = 0; j < ENTRIES; j++) begin
      hit_vec[j] = valid_r[j] && (key_r[j] == key);
      hit_value  = hit_value | (value_r[j] & {DATA_BITS{hit_vec[j]}});
      hit_age    = hit_age | (age_r[j] & {AGE_W{hit_vec[j]}});
    end
  end
  assign hit = |hit_vec;

  // Capacity clamped to the range one to ENTRIES.
  always_comb begin
    eff_cap = CMP_W'(capacity);
    if (capacity == '0) begin
      eff_cap = CMP_W'(1);
    end else if (CMP_W'(capacity) > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end
  end
  assign full = CMP_W'(count_r) >= eff_cap;

  // Valid ages are always 0 .. count-1, so the least recent entry
  // is the valid one whose age equals count-1.
  assign count_m1 = count_r - CNT_W'(1);
  always_comb begin
    for (int j = 0; j < ENTRIES; j++) begin
      lru_vec[j] = valid_r[j] && (age_r[j] == count_m1[AGE_W-1:0]);
    end
  end

  // Lowest free entry, isolated as the lowest set bit.
  assign free_vec   = ~valid_r;
  assign free_first = free_vec & (~free_vec + ENTRIES'(1));
  assign slot_vec   = full ? lru_vec : free_first;

  // Next state of the recency ages, valid bits and fill count.
  always_comb begin
    valid_nxt = valid_r;
    count_nxt = count_r;
    wr_vec    = '0;
    for (int j = 0; j < ENTRIES; j++) begin
      age_nxt[j] = age_r[j];
    end
    if (op_valid) begin
      if (hit) begin
        // Promote the hit entry; younger entries age by one.
        if (is_put) begin
          wr_vec = hit_vec;
        end
        for (int j = 0; j < ENTRIES; j++) begin
          if (hit_vec[j]) begin
            age_nxt[j] = '0;
          end else if (valid_r[j] && (age_r[j] < hit_age)) begin
            age_nxt[j] = age_r[j] + AGE_W'(1);
          end
        end
      end else if (is_put) begin
        // Insert into the chosen slot, evicting it first when full.
        wr_vec    = slot_vec;
        valid_nxt = valid_r | slot_vec;
        if (!full) begin
          count_nxt = count_r + CNT_W'(1);
        end
        for (int j = 0; j < ENTRIES; j++) begin
          if (slot_vec[j]) begin
            age_nxt[j] = '0;
          end else if (valid_r[j]) begin
            age_nxt[j] = age_r[j] + AGE_W'(1);
          end
        end
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
      for (int j = 0; j < ENTRIES; j++) begin
        age_r[j] <= '0;
      end
    end else begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
      for (int j = 0; j < ENTRIES; j++) begin
        age_r[j] <= age_nxt[j];
      end
    end
  end

  // Key and value storage, written per entry.
  always_ff @(posedge clk) begin
    for (int j = 0; j < ENTRIES; j++) begin
      if (wr_vec[j]) begin
        key_r[j]   <= key;
        value_r[j] <= op.put_value;
      end
    end
  end

  // Result of this item, taken from the state before the update.
  always_comb begin
    res.found      = hit;
    res.read_value = '0;
    if (hit && !is_put) begin
      res.read_value = hit_value;
    end
  end

endmodule

/* design/lru_key_value_cache.sv */
// Fully associative key-value store with least-recently-used replacement.
// An item is taken on any clock edge where start is high; busy never rises,
// so one item can be issued every cycle. Each item gives exactly one result,
// shown on out_item for one cycle with out_valid high. The edge that takes
// the item loads the input register; the key compare and recency update sit
// between it and the result register, which drives the result strobe. The
// receiver cannot stall; it must capture every result in its strobe cycle.
// No clearing pass runs after reset. Write capacity only while no items are
// in flight.
module lru_key_value_cache #(
  parameter int ENTRIES  = lkvc_pkg::ENTRIES_DEF,
  parameter int KEY_BITS = lkvc_pkg::KEY_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  lkvc_pkg::in_item_t                 in_item,
  output logic                               out_valid,
  output lkvc_pkg::out_item_t                out_item,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lkvc_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [lkvc_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [lkvc_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                               pready
);
  import lkvc_pkg::*;

  logic                in_valid_r;
  in_item_t            in_item_r;
  logic                out_valid_r;
  out_item_t           out_item_r;
  out_item_t           res;
  logic [CAP_BITS-1:0] capacity;

  // The store takes every item without stalling, so busy stays low.
  assign busy = 1'b0;

  lkvc_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .capacity (capacity)
  );

  lkvc_store #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_valid (in_valid_r),
    .op       (in_item_r),
    .capacity (capacity),
    .res      (res)
  );

  // Input register and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= start && !busy;
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_item_r <= in_item;
    end
    if (in_valid_r) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
